FILE: sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BCA_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/bca_pkg.sv
// Shared types and constants of the bitmap cluster allocator.
// Used by bca_cfg, bca_core and bitmap_cluster_allocator_top; depends on nothing.
package bca_pkg;

	// Internal cluster number width, wide enough for the largest map and its count
	localparam int CLUSTER_W = 17;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	localparam logic [2:0] ACT_ALLOC  = 3'd0;
	localparam logic [2:0] ACT_FREE   = 3'd1;
	localparam logic [2:0] ACT_FORMAT = 3'd2;
	localparam logic [2:0] ACT_LOAD   = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	localparam logic [CLUSTER_W-1:0] FIRST_USABLE = CLUSTER_W'(2);

	localparam logic [1:0]  REG_CLUSTER_COUNT = 2'd0;
	localparam logic [14:0] CLUSTER_COUNT_RST = 15'd16384;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [10:0] byte_index;
		logic [13:0] cluster_index;
		logic [2:0]  action;
	} req_t;

	typedef struct packed {
		logic        map_dirty;
		logic [7:0]  map_byte;
		logic        success;
		logic [13:0] allocated_cluster;
	} result_t;

endpackage

FILE: sv/bca_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; instanced for the free map.
module bca_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/bca_cfg.sv
// APB-style configuration register block: holds the cluster count.
// Depends on bca_pkg for the register address and reset value.
module bca_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [14:0] cluster_count
);

	logic [14:0] cluster_count_q;
	logic        wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && pready && (paddr == bca_pkg::REG_CLUSTER_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= bca_pkg::CLUSTER_COUNT_RST;
		end else if (wr_hit) begin
			cluster_count_q <= pwdata[14:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == bca_pkg::REG_CLUSTER_COUNT) begin
			prdata = {17'd0, cluster_count_q};
		end
	end

	assign cluster_count = cluster_count_q;

endmodule

FILE: sv/bca_core.sv
// Allocator engine: request sequencer, word scan and read-modify-write of the free map.
// Depends on bca_pkg, bca_ram and assert_macros.svh.
`include "assert_macros.svh"

module bca_core #(
	parameter int MAX_CLUSTERS  = 16384,
	parameter int MAP_WORD_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [14:0]       cluster_count,
	input  logic              req_valid,
	output logic              req_ready,
	input  bca_pkg::req_t     req,
	input  logic              out_free,
	output logic              res_push,
	output bca_pkg::result_t  res
);

	// Stored word is the map word width rounded up to a power of two
	localparam int WB    = 2 ** $clog2(MAP_WORD_BITS);
	localparam int BB    = $clog2(WB);
	localparam int WORDS = (MAX_CLUSTERS + WB - 1) / WB;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW    = bca_pkg::CLUSTER_W;

	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
	localparam logic [CW-1:0] MAX_C     = CW'(MAX_CLUSTERS);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_FMT  = 3'd4;
	localparam logic [2:0] ST_POST = 3'd5;

	typedef logic [WB-1:0] word_t;

	logic [2:0]       state_q;
	logic [AW-1:0]    sweep_q;
	logic [AW-1:0]    hint_q;
	logic [AW:0]      scan_q;
	logic             dirty_q;
	bca_pkg::req_t    req_q;
	logic [AW-1:0]    word_q;
	logic [BB-1:0]    off_q;
	bca_pkg::result_t res_q;
	logic             chk_vld_s1;
	logic [AW-1:0]    chk_addr_s1;

	logic [CW-1:0]    cnt;
	logic             in_accept;
	logic [CW-1:0]    cidx_ext;
	logic [CW-1:0]    byte_base;
	logic             free_ok;
	logic             byte_ok;
	logic [CW-1:0]    in_cl;
	logic [AW-1:0]    in_word;
	logic [BB-1:0]    in_off;
	logic             in_rd;

	logic [AW-1:0]    mask_addr;
	word_t            vis_mask;
	word_t            masked;
	logic             hit;
	logic [BB-1:0]    pos;
	logic             issue_ok;
	logic             scan_rd;
	word_t            load_word;
	logic [7:0]       rbyte;
	logic [CW-1:0]    alloc_full;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	word_t            wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	word_t            rd_data;

	// Effective count: the register clipped to the map size
	always_comb begin
		cnt = (CW'(cluster_count) > MAX_C) ? MAX_C : CW'(cluster_count);
	end

	assign req_ready = (state_q == ST_IDLE);
	assign in_accept = req_valid && req_ready;

	always_comb begin
		cidx_ext  = CW'(req.cluster_index);
		byte_base = CW'({req.byte_index, 3'b000});
		free_ok   = (cidx_ext >= bca_pkg::FIRST_USABLE) && (cidx_ext < cnt);
		byte_ok   = (byte_base < MAX_C);
		in_cl     = (req.action == bca_pkg::ACT_FREE) ? cidx_ext : byte_base;
		in_word   = AW'(in_cl >> BB);
		in_off    = in_cl[BB-1:0];
		in_rd     = in_accept && (((req.action == bca_pkg::ACT_FREE) && free_ok) ||
			(((req.action == bca_pkg::ACT_LOAD) || (req.action == bca_pkg::ACT_READ)) &&
			byte_ok));
	end

	// Mask of bits in the current word that the count and the reserved clusters leave visible
	always_comb begin
		logic [CW-1:0] ws;
		logic [CW-1:0] c;
		unique case (state_q)
			ST_SCAN: mask_addr = chk_addr_s1;
			ST_FMT:  mask_addr = sweep_q;
			default: mask_addr = word_q;
		endcase
		ws = CW'(mask_addr) << BB;
		for (int k = 0; k < WB; k++) begin
			c = ws + CW'(k);
			vis_mask[k] = (c >= bca_pkg::FIRST_USABLE) && (c < cnt);
		end
	end

	always_comb begin
		masked   = rd_data & vis_mask;
		hit      = chk_vld_s1 && (|masked);
		pos      = '0;
		for (int k = WB - 1; k >= 0; k--) begin
			if (masked[k]) begin
				pos = BB'(k);
			end
		end
		issue_ok   = ((CW'(scan_q) << BB) < cnt);
		scan_rd    = (state_q == ST_SCAN) && issue_ok && !hit;
		alloc_full = (CW'(chk_addr_s1) << BB) | CW'(pos);
	end

	// Byte lane update for load and extraction for read
	always_comb begin
		load_word = rd_data;
		rbyte     = '0;
		for (int k = 0; k < WB; k++) begin
			if ((BB'(k) & ~BB'(7)) == off_q) begin
				load_word[k] = req_q.byte_value[k % 8] & vis_mask[k];
				rbyte[k % 8] = rd_data[k] & vis_mask[k];
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = word_q;
		wr_data = rd_data;
		unique case (state_q)
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = '0;
			end
			ST_EXEC: begin
				wr_en   = (req_q.action == bca_pkg::ACT_FREE) ||
					(req_q.action == bca_pkg::ACT_LOAD);
				wr_addr = word_q;
				wr_data = (req_q.action == bca_pkg::ACT_FREE) ?
					(rd_data | (word_t'(1) << off_q)) : load_word;
			end
			ST_SCAN: begin
				wr_en   = hit;
				wr_addr = chk_addr_s1;
				wr_data = rd_data & ~(word_t'(1) << pos);
			end
			ST_FMT: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = vis_mask;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		rd_en   = in_rd || scan_rd;
		rd_addr = (state_q == ST_SCAN) ? scan_q[AW-1:0] : in_word;
	end

	bca_ram #(
		.WIDTH (WB),
		.DEPTH (WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			sweep_q    <= '0;
			hint_q     <= '0;
			dirty_q    <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= scan_rd;
			unique case (state_q)
				ST_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_WORD) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						sweep_q <= '0;
						unique case (req.action) inside
							bca_pkg::ACT_ALLOC:  state_q <= ST_SCAN;
							bca_pkg::ACT_FREE:   state_q <= free_ok ? ST_EXEC : ST_POST;
							bca_pkg::ACT_FORMAT: state_q <= ST_FMT;
							bca_pkg::ACT_LOAD, bca_pkg::ACT_READ: begin
								state_q <= byte_ok ? ST_EXEC : ST_POST;
							end
							default: state_q <= ST_POST;
						endcase
					end
				end
				ST_EXEC: begin
					if (req_q.action == bca_pkg::ACT_FREE) begin
						dirty_q <= 1'b1;
					end
					// Freed or loaded bits may sit below the scan start: pull it down
					if (((req_q.action == bca_pkg::ACT_FREE) ||
						(req_q.action == bca_pkg::ACT_LOAD)) && (word_q < hint_q)) begin
						hint_q <= word_q;
					end
					state_q <= ST_POST;
				end
				ST_SCAN: begin
					if (hit) begin
						dirty_q <= 1'b1;
						hint_q  <= chk_addr_s1;
						state_q <= ST_POST;
					end else if (!issue_ok) begin
						state_q <= ST_POST;
					end
				end
				ST_FMT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_WORD) begin
						sweep_q <= '0;
						dirty_q <= 1'b1;
						hint_q  <= '0;
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload, scan pointer and result fields
	always_ff @(posedge clk) begin
		chk_addr_s1 <= scan_q[AW-1:0];
		if (in_accept) begin
			req_q  <= req;
			word_q <= in_word;
			off_q  <= in_off;
			scan_q <= {1'b0, hint_q};
			res_q  <= '0;
		end
		if (scan_rd) begin
			scan_q <= scan_q + 1'b1;
		end
		if (state_q == ST_EXEC) begin
			res_q.success <= 1'b1;
			if (req_q.action == bca_pkg::ACT_READ) begin
				res_q.map_byte <= rbyte;
			end
		end
		if (hit && (state_q == ST_SCAN)) begin
			res_q.success           <= 1'b1;
			res_q.allocated_cluster <= alloc_full[13:0];
		end
		if ((state_q == ST_FMT) && (sweep_q == LAST_WORD)) begin
			res_q.success <= 1'b1;
		end
	end

	assign res_push = (state_q == ST_POST) && out_free;

	always_comb begin
		res           = res_q;
		res.map_dirty = dirty_q;
	end

	`BCA_ASSERT(a_idle_no_write, state_q == ST_IDLE, !wr_en, "map written while idle")
	`BCA_ASSERT(a_push_needs_room, res_push, out_free, "result pushed into a full output")
	`BCA_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_q != ST_IDLE,
		"request accepted but sequencer stayed idle")
	`BCA_ASSERT(a_check_only_in_scan, chk_vld_s1, state_q == ST_SCAN,
		"scan check pending outside the scan")

endmodule

FILE: sv/bitmap_cluster_allocator_top.sv
// Top level of the bitmap cluster allocator: stream ports, APB register port, output register.
// Depends on bca_pkg, bca_cfg and bca_core.

// The free map (1 = free) lives in one RAM of MAX_CLUSTERS/word-width words, with
// clusters 0 and 1 and everything at or above the count never freed or handed out.
// After reset the block sweeps the RAM to zero, one word a cycle, and takes no
// request until that is done; the register port works throughout. One request is in
// flight at a time. Free, load byte and read byte go from accept to result through
// accept and read, modify and write, and hand-off; a rejected free, load or read
// and an unused action code skip the middle step. Allocate reads map words one per
// cycle starting from the lowest word that may hold a free cluster, and scans words
// until it finds a free cluster or reaches the count (one word when the lowest free
// cluster sits in that word, at most 256 at the defaults). Format writes every word
// once. The hand-off step stretches while the output register still holds an unread
// result. The next request is taken while a finished result still waits in the
// output register.
module bitmap_cluster_allocator_top #(
	parameter int MAX_CLUSTERS  = 16384,
	parameter int MAP_WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: action[2:0], cluster_index[16:3], byte_index[27:17], byte_value[35:28], zero pad
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// m_tdata: allocated_cluster[13:0], success[14], map_byte[22:15], map_dirty[23]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [14:0]      cluster_count;
	bca_pkg::req_t    req;
	bca_pkg::result_t res;
	logic             res_push;
	logic             out_free;
	logic             m_tvalid_q;
	logic [23:0]      m_tdata_q;

	bca_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.cluster_count (cluster_count)
	);

	always_comb begin
		req.action        = s_tdata[2:0];
		req.cluster_index = s_tdata[16:3];
		req.byte_index    = s_tdata[27:17];
		req.byte_value    = s_tdata[35:28];
	end

	assign out_free = !m_tvalid_q || m_tready;

	bca_core #(
		.MAX_CLUSTERS  (MAX_CLUSTERS),
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cluster_count (cluster_count),
		.req_valid     (s_tvalid),
		.req_ready     (s_tready),
		.req           (req),
		.out_free      (out_free),
		.res_push      (res_push),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			m_tdata_q <= {res.map_dirty, res.map_byte, res.success, res.allocated_cluster};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
